[hw/rtl/twhq_pkg.sv]
// Shared constants for the timed wakeup heap queue: wake time width, request modes, result kinds.
package twhq_pkg;

  // Width of a wake time in ticks
  localparam int TIME_BITS = 32;

  // Request modes
  localparam logic MODE_SCHEDULE = 1'b0;
  localparam logic MODE_TICK     = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_WOKEN    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

endpackage

[hw/rtl/twhq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module twhq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/timed_wakeup_heap_queue.sv]
// Timed wakeup queue: bounded binary min-heap of (wake time, task id) entries.
// Schedule: the new entry climbs from the last slot, one parent read and compare per level;
// a full queue gets a full result and a tick on an empty queue a nothing-due result.
// Tick: each due root is released and the last entry sifts down from the root, at most
// log2(CAPACITY) levels; the steps are set by the one RAM read port and one comparator.
// One request at a time. Synchronous reset empties the queue at once; heap RAM is not cleared.
module timed_wakeup_heap_queue #(
  parameter int CAPACITY     = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [31:0]                time_value,
  input  logic [TASK_ID_BITS-1:0]    task_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [TASK_ID_BITS-1:0]    woken_task,
  output logic [31:0]                due_time,
  output logic                       last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int EW = twhq_pkg::TIME_BITS + TASK_ID_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_UP, S_UP_CMP, S_ROOT_RD, S_ROOT_CHK,
    S_MOV_RD, S_MOV_GET, S_DN_L, S_DN_LC, S_DN_RC, S_DN_MV
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [IW-1:0]   idx;
  logic [EW-1:0]   mov;
  logic [EW-1:0]   cand;
  logic [IW-1:0]   cand_idx;
  logic            cand_child;
  logic [EW-1:0]   pend;
  logic            have_pend;
  logic [31:0]     tick_time;
  logic [1:0]      fin_kind;

  // RAM port signals
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   rd_data;

  // Shared comparator
  logic [31:0]     cmp_a;
  logic [31:0]     cmp_b;
  logic            cmp_lt;

  logic [31:0]     rd_t;
  logic [31:0]     mov_t;
  logic [31:0]     cand_t;
  logic [IW-1:0]   parent;
  logic [XW-1:0]   child_l;
  logic [XW-1:0]   child_r;
  logic [XW-1:0]   count_x;
  logic            l_ok;
  logic            r_ok;
  logic            due;
  logic            out_free;
  logic            proceed;

  twhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign rd_t     = rd_data[EW-1:TASK_ID_BITS];
  assign mov_t    = mov[EW-1:TASK_ID_BITS];
  assign cand_t   = cand[EW-1:TASK_ID_BITS];
  assign parent   = (idx - IW'(1)) >> 1;
  assign child_l  = {1'b0, idx, 1'b1};
  assign child_r  = child_l + XW'(1);
  assign count_x  = XW'(count);
  assign l_ok     = child_l < count_x;
  assign r_ok     = child_r < count_x;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign due      = (count != '0) && cmp_lt;
  assign proceed  = out_free || (due && !have_pend);

  // Comparator operand select
  always_comb begin
    cmp_a = rd_t;
    cmp_b = mov_t;
    case (state)
      S_UP_CMP: begin
        cmp_a = mov_t;
        cmp_b = rd_t;
      end
      S_ROOT_CHK: cmp_b = tick_time;
      S_DN_RC:    cmp_b = cand_t;
      default:    cmp_b = mov_t;
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  // Heap RAM addressing: the moving entry rides in mov, the hole sits at idx
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = mov;
    ram_raddr = '0;
    case (state)
      S_UP: begin
        if (idx != '0) begin
          ram_raddr = parent;
        end else begin
          ram_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = cmp_lt ? rd_data : mov;
      end
      S_MOV_RD: ram_raddr = count[IW-1:0];
      S_DN_L: begin
        if (l_ok) begin
          ram_raddr = child_l[IW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_DN_LC: begin
        if (r_ok) begin
          ram_raddr = child_r[IW-1:0];
        end
      end
      S_DN_MV: begin
        ram_we    = 1'b1;
        ram_wdata = cand_child ? cand : mov;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tick_time <= time_value;
            mov       <= {time_value, task_id};
            idx       <= count[IW-1:0];
            have_pend <= 1'b0;
            if (mode == twhq_pkg::MODE_SCHEDULE) begin
              if (count == CW'(CAPACITY)) begin
                fin_kind <= twhq_pkg::KIND_FULL;
                state    <= S_FIN;
              end else begin
                count <= count + CW'(1);
                state <= S_UP;
              end
            end else if (count == '0) begin
              fin_kind <= twhq_pkg::KIND_NONE;
              state    <= S_FIN;
            end else begin
              state <= S_ROOT_RD;
            end
          end
        end
        // Single closing result
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= fin_kind;
            woken_task <= '0;
            due_time   <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        // Sift up: parent read issued here
        S_UP: begin
          if (idx == '0) begin
            fin_kind <= twhq_pkg::KIND_ACCEPTED;
            state    <= S_FIN;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (cmp_lt) begin
            idx   <= parent;
            state <= S_UP;
          end else begin
            fin_kind <= twhq_pkg::KIND_ACCEPTED;
            state    <= S_FIN;
          end
        end
        S_ROOT_RD: state <= S_ROOT_CHK;
        // Root due check; emits the previous pop once its last flag is known
        S_ROOT_CHK: begin
          if (proceed) begin
            if (have_pend) begin
              out_valid  <= 1'b1;
              kind       <= twhq_pkg::KIND_WOKEN;
              woken_task <= pend[TASK_ID_BITS-1:0];
              due_time   <= pend[EW-1:TASK_ID_BITS];
              last       <= !due;
            end else if (!due) begin
              out_valid  <= 1'b1;
              kind       <= twhq_pkg::KIND_NONE;
              woken_task <= '0;
              due_time   <= '0;
              last       <= 1'b1;
            end
            if (due) begin
              pend      <= rd_data;
              have_pend <= 1'b1;
              count     <= count - CW'(1);
              state     <= (count == CW'(1)) ? S_ROOT_RD : S_MOV_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MOV_RD: state <= S_MOV_GET;
        // Former last entry becomes the moving entry, hole at the root
        S_MOV_GET: begin
          mov   <= rd_data;
          idx   <= '0;
          state <= S_DN_L;
        end
        S_DN_L: state <= l_ok ? S_DN_LC : S_ROOT_RD;
        S_DN_LC: begin
          if (cmp_lt) begin
            cand       <= rd_data;
            cand_child <= 1'b1;
            cand_idx   <= child_l[IW-1:0];
          end else begin
            cand       <= mov;
            cand_child <= 1'b0;
          end
          state <= r_ok ? S_DN_RC : S_DN_MV;
        end
        S_DN_RC: begin
          if (cmp_lt) begin
            cand       <= rd_data;
            cand_child <= 1'b1;
            cand_idx   <= child_r[IW-1:0];
          end
          state <= S_DN_MV;
        end
        S_DN_MV: begin
          if (cand_child) begin
            idx   <= cand_idx;
            state <= S_DN_L;
          end else begin
            state <= S_ROOT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/twhq_checker.sv]
// Port-level assertions for the timed wakeup heap queue, bound to the top level.
module twhq_checker #(
  parameter int TASK_ID_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              kind,
  input logic [TASK_ID_BITS-1:0] woken_task,
  input logic [31:0]             due_time,
  input logic                    last
);

  // One request at a time: busy right after taking one
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous still in work");

  // Only woken results carry a task and time
  a_idle_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != twhq_pkg::KIND_WOKEN) |-> (woken_task == '0) && (due_time == '0))
    else $error("non-woken result carries task or time");

  // Accepted, full and nothing-due results close their request
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != twhq_pkg::KIND_WOKEN) |-> last)
    else $error("single result not marked last");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(woken_task)
      && $stable(due_time) && $stable(last))
    else $error("stalled result changed");

endmodule

bind timed_wakeup_heap_queue twhq_checker #(
  .TASK_ID_BITS (TASK_ID_BITS)
) u_twhq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .woken_task (woken_task),
  .due_time   (due_time),
  .last       (last)
);

[tb/sv/tb.sv]
// Testbench for timed_wakeup_heap_queue: random and directed requests against a heap predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CAPACITY     = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int LAST_CALM    = 40;   // final requests sent with no idling
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic                    mode;
    logic [31:0]             time_value;
    logic [TASK_ID_BITS-1:0] task_id;
  } request_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [TASK_ID_BITS-1:0] woken_task;
    logic [31:0]             due_time;
    logic                    last;
  } wake_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    mode = twhq_pkg::MODE_SCHEDULE;
  logic [31:0]             time_value = '0;
  logic [TASK_ID_BITS-1:0] task_id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              kind;
  logic [TASK_ID_BITS-1:0] woken_task;
  logic [31:0]             due_time;
  logic                    last;

  request_t     request_q[$];
  wake_result_t wake_results_due[$];

  // predictor state: mirror of the heap
  logic [31:0]             pred_time[CAPACITY];
  logic [TASK_ID_BITS-1:0] pred_task[CAPACITY];
  int                      pred_count = 0;

  int   error_count = 0;
  int   requests_taken = 0;
  logic took_req = 1'b0;
  logic hold_out = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;

  // no idling once the last stretch of requests is reached
  function automatic logic in_calm();
    return request_q.size() < LAST_CALM;
  endfunction

  timed_wakeup_heap_queue #(
    .CAPACITY    (CAPACITY),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .time_value(time_value),
    .task_id   (task_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .woken_task(woken_task),
    .due_time  (due_time),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void swap_slots(int a, int b);
    logic [31:0]             t;
    logic [TASK_ID_BITS-1:0] d;
    t = pred_time[a];
    d = pred_task[a];
    pred_time[a] = pred_time[b];
    pred_task[a] = pred_task[b];
    pred_time[b] = t;
    pred_task[b] = d;
  endfunction

  // Append one expected result
  function automatic void queue_result(wake_result_t res);
    wake_results_due.insert(wake_results_due.size(), res);
  endfunction

  // Apply one request to the heap mirror and queue the results it causes
  function automatic void predict_wakeups(request_t rq);
    int                      i;
    int                      p;
    int                      l;
    int                      r;
    int                      m;
    int                      n;
    logic [31:0]             t;
    logic [TASK_ID_BITS-1:0] d;
    n = 0;
    if (rq.mode == twhq_pkg::MODE_SCHEDULE) begin
      if (pred_count >= CAPACITY) begin
        queue_result('{twhq_pkg::KIND_FULL, '0, '0, 1'b1});
      end else begin
        pred_time[pred_count] = rq.time_value;
        pred_task[pred_count] = rq.task_id;
        i = pred_count;
        pred_count++;
        // climb while strictly earlier than the parent
        while (i > 0) begin
          p = (i - 1) / 2;
          if (pred_time[i] < pred_time[p]) begin
            swap_slots(i, p);
            i = p;
          end else begin
            break;
          end
        end
        queue_result('{twhq_pkg::KIND_ACCEPTED, '0, '0, 1'b1});
      end
    end else begin
      // release every entry strictly earlier than the tick time
      while (pred_count > 0 && pred_time[0] < rq.time_value) begin
        t = pred_time[0];
        d = pred_task[0];
        pred_count--;
        pred_time[0] = pred_time[pred_count];
        pred_task[0] = pred_task[pred_count];
        i = 0;
        // sift down, left child wins ties
        while (1'b1) begin
          l = 2 * i + 1;
          r = l + 1;
          m = i;
          if (l < pred_count && pred_time[l] < pred_time[m]) m = l;
          if (r < pred_count && pred_time[r] < pred_time[m]) m = r;
          if (m == i) break;
          swap_slots(i, m);
          i = m;
        end
        queue_result('{twhq_pkg::KIND_WOKEN, d, t, 1'b0});
        n++;
      end
      if (n == 0) begin
        queue_result('{twhq_pkg::KIND_NONE, '0, '0, 1'b1});
      end else begin
        wake_results_due[wake_results_due.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic void add_request(logic m, logic [31:0] tv, logic [TASK_ID_BITS-1:0] tid);
    request_t rq;
    rq = '{m, tv, tid};
    request_q.insert(request_q.size(), rq);
  endfunction

  // Request acceptance: feed the predictor
  always @(posedge clk) begin
    took_req <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_wakeups('{mode, time_value, task_id});
      requests_taken++;
    end
  end

  // Driver: new request or idle burst at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took_req) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (request_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!in_calm() && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(1, 14) - 1;
      in_valid <= 1'b0;
    end else begin
      in_valid   <= 1'b1;
      mode       <= request_q[0].mode;
      time_value <= request_q[0].time_value;
      task_id    <= request_q[0].task_id;
      void'(request_q.pop_front());
    end
  end

  // Receiver readiness, with idle bursts and the long hold-off
  always @(negedge clk) begin
    if (rst || hold_out) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!in_calm() && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    wake_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (wake_results_due.size() == 0) begin
        $error("unexpected result: kind %0d task %0d due %0d last %0d",
               kind, woken_task, due_time, last);
        error_count++;
      end else begin
        exp_res = wake_results_due.pop_front();
        if (kind !== exp_res.kind) begin
          $error("kind: expected %0d, got %0d", exp_res.kind, kind);
          error_count++;
        end
        if (woken_task !== exp_res.woken_task) begin
          $error("woken_task: expected %0d, got %0d", exp_res.woken_task, woken_task);
          error_count++;
        end
        if (due_time !== exp_res.due_time) begin
          $error("due_time: expected %0d, got %0d", exp_res.due_time, due_time);
          error_count++;
        end
        if (last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, last);
          error_count++;
        end
      end
    end
  end

  // Long receiver stall so the queue backs up into the input
  initial begin
    while (requests_taken < 80) @(posedge clk);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] now;
    int          sel;
    int          burst;
    int          pick;
    logic [31:0] wake;

    // empty-queue ticks at both extremes
    add_request(twhq_pkg::MODE_TICK, 32'h0, 8'h00);
    add_request(twhq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'hFF);
    // wake at zero, near max, and a tie of three
    add_request(twhq_pkg::MODE_SCHEDULE, 32'h0, 8'h00);
    add_request(twhq_pkg::MODE_SCHEDULE, 32'hFFFF_FFFE, 8'hFF);
    add_request(twhq_pkg::MODE_SCHEDULE, 32'd5, 8'hA5);
    add_request(twhq_pkg::MODE_SCHEDULE, 32'd5, 8'h5A);
    add_request(twhq_pkg::MODE_SCHEDULE, 32'd5, 8'h33);
    // tick equal to a wake time does not release it
    add_request(twhq_pkg::MODE_TICK, 32'd5, 8'h00);
    add_request(twhq_pkg::MODE_TICK, 32'd6, 8'h00);
    // fill to capacity with falling times, then overflow
    for (int k = 0; k < CAPACITY - 1; k++) begin
      add_request(twhq_pkg::MODE_SCHEDULE, 32'd1000 - 32'(37 * k), 8'(k * 17));
    end
    add_request(twhq_pkg::MODE_SCHEDULE, 32'd77, 8'hC3);
    // release everything
    add_request(twhq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'h00);

    // random part: schedule bursts followed by a tick, plus some noise
    now = $urandom_range(0, 1000);
    while (request_q.size() < 310) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        add_request(1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)));
      end else begin
        burst = $urandom_range(1, (sel < 5) ? 18 : 6);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            wake = $urandom;
          end else if ($urandom_range(0, 3) == 0) begin
            wake = now + 32'(40 * $urandom_range(0, 2));
          end else begin
            wake = now + 32'($urandom_range(0, 200));
          end
          add_request(twhq_pkg::MODE_SCHEDULE, wake, 8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          add_request(twhq_pkg::MODE_TICK, 32'hFFFF_FFFF, 8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          add_request(twhq_pkg::MODE_TICK, 32'h0, 8'($urandom_range(0, 255)));
        end else if (pick == 2) begin
          now = $urandom;
          add_request(twhq_pkg::MODE_TICK, now, 8'($urandom_range(0, 255)));
        end else begin
          now = now + 32'($urandom_range(0, 150));
          add_request(twhq_pkg::MODE_TICK, now, 8'($urandom_range(0, 255)));
        end
      end
    end

    // hold reset, then release it at a falling edge
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || in_valid || wake_results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
